FILE: rtl/core/rptw_pkg.sv
// Shared widths, codes and controller/datapath interface types for the page table walker.
`timescale 1ns / 1ps

package rptw_pkg;

    // Fixed field widths
    localparam int REQ_W     = 2;
    localparam int VPN_W     = 45;
    localparam int PAGE_W    = 52;
    localparam int ENTRY_W   = PAGE_W + 1;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MAP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UNMAP = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_MAP    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_FRAMES = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'd1;

    // Commands from controller to datapath
    typedef struct packed {
        logic              clr_step;
        logic              load_req;
        logic              mod_root;
        logic              mod_entry;
        logic              adv_level;
        logic              mark_missing;
        logic              alloc_write;
        logic              leaf_write;
        logic              unmap_write;
        logic              set_result;
        logic [STAT_W-1:0] result_code;
        logic              phys_sel;
        logic              out_load;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic             clr_last;
        logic             mod_done;
        logic             entry_valid;
        logic             level_last;
        logic             level_pre_last;
        logic             fits;
        logic             out_free;
        logic [REQ_W-1:0] kind;
    } t_dp_sts;

endpackage

FILE: rtl/core/rptw_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module rptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read of the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/rptw_frame_mod.sv
// Reduces a page number modulo the frame count: keeps the low bits for a power of two, else 4 bits a cycle.
`timescale 1ns / 1ps

module rptw_frame_mod #(
    parameter int NUM_FRAMES = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rptw_pkg::PAGE_W-1:0]   i_value,
    output logic                          o_done,
    output logic [$clog2(NUM_FRAMES)-1:0] o_result
);
    import rptw_pkg::*;

    localparam int FRAME_W = $clog2(NUM_FRAMES);
    localparam bit IS_POW2 = (NUM_FRAMES & (NUM_FRAMES - 1)) == 0;

    generate
        if (IS_POW2) begin : g_pow2
            logic               r_done;
            logic [FRAME_W-1:0] r_res;

            // Keep the low bits
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_res <= i_value[FRAME_W-1:0];
                end
            end

            assign o_done   = r_done;
            assign o_result = r_res;
        end else begin : g_serial
            localparam int STEP  = 4;
            localparam int STEPS = PAGE_W / STEP;
            localparam int CNT_W = $clog2(STEPS);
            localparam logic [FRAME_W:0] MOD_N = (FRAME_W + 1)'(NUM_FRAMES);

            logic               r_busy;
            logic               r_done;
            logic [CNT_W-1:0]   r_cnt;
            logic [PAGE_W-1:0]  r_val;
            logic [FRAME_W-1:0] r_rem;
            logic [PAGE_W-1:0]  n_val;
            logic [FRAME_W-1:0] n_rem;

            // Shift in four bits, subtracting the modulus where it fits
            always_comb begin
                logic [FRAME_W:0] t;
                n_rem = r_rem;
                n_val = r_val;
                t     = '0;
                for (int k = 0; k < STEP; k++) begin
                    t = {n_rem, n_val[PAGE_W-1]};
                    if (t >= MOD_N) begin
                        t = t - MOD_N;
                    end
                    n_rem = t[FRAME_W-1:0];
                    n_val = {n_val[PAGE_W-2:0], 1'b0};
                end
            end

            // Sequence the digit steps
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_cnt  <= '0;
                    end else if (r_busy) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == CNT_W'(STEPS - 1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_val <= i_value;
                    r_rem <= '0;
                end else if (r_busy) begin
                    r_val <= n_val;
                    r_rem <= n_rem;
                end
            end

            assign o_done   = r_done;
            assign o_result = r_rem;
        end
    endgenerate

endmodule

FILE: rtl/core/rptw_datapath.sv
// Walker datapath: request and walk registers, allocator, config, frame store and result beat.
`timescale 1ns / 1ps

module rptw_datapath #(
    parameter int NUM_FRAMES = 1024,
    parameter int NUM_LEVELS = 5,
    parameter int INDEX_BITS = 9
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rptw_pkg::t_dp_cmd                i_cmd,
    output rptw_pkg::t_dp_sts                o_sts,
    input  logic [rptw_pkg::REQ_W-1:0]       i_req_type,
    input  logic [rptw_pkg::VPN_W-1:0]       i_virt_page,
    input  logic [rptw_pkg::PAGE_W-1:0]      i_map_page,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rptw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rptw_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [rptw_pkg::STAT_W-1:0]      o_status,
    output logic [rptw_pkg::PAGE_W-1:0]      o_phys_page
);
    import rptw_pkg::*;

    localparam int FRAME_W  = $clog2(NUM_FRAMES);
    localparam int DEPTH    = NUM_FRAMES << INDEX_BITS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int LVL_W    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int USED_W   = $clog2(NUM_FRAMES + 1);
    localparam int SUM_W    = ((USED_W > CFG_W) ? USED_W : CFG_W) + 2;
    localparam int SLOT_TOP = NUM_LEVELS * INDEX_BITS;
    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(NUM_LEVELS - 1);

    // Request and walk state
    logic [REQ_W-1:0]   r_kind;
    logic [VPN_W-1:0]   r_vpn;
    logic [PAGE_W-1:0]  r_page;
    logic [FRAME_W-1:0] r_frame;
    logic [LVL_W-1:0]   r_level;
    logic [LVL_W-1:0]   r_first_missing;

    // Config, allocator and clearing pass
    logic [CFG_W-1:0]   r_root;
    logic [CFG_W-1:0]   r_first_free;
    logic [USED_W-1:0]  r_used;
    logic [ADDR_W-1:0]  r_clr_addr;

    // Result and output beat
    logic [STAT_W-1:0]  r_status;
    logic [PAGE_W-1:0]  r_phys;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_out_status;
    logic [PAGE_W-1:0]  r_out_phys;

    logic [INDEX_BITS-1:0] slot;
    logic [ADDR_W-1:0]     ram_addr;
    logic                  ram_we;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    rd_data;
    logic [LVL_W-1:0]      need;
    logic [SUM_W-1:0]      nf;
    logic [SUM_W-1:0]      demand;
    logic [FRAME_W-1:0]    nf_frame;
    logic                  mod_start;
    logic [PAGE_W-1:0]     mod_value;
    logic                  mod_done;
    logic [FRAME_W-1:0]    mod_result;

    // Table index of the current level sits at the top of the shifted page number
    assign slot = r_vpn[SLOT_TOP-1 -: INDEX_BITS];

    // Allocator arithmetic
    assign need     = LAST_LVL - r_first_missing;
    assign nf       = SUM_W'(r_first_free) + SUM_W'(r_used);
    assign demand   = nf + SUM_W'(need);
    assign nf_frame = nf[FRAME_W-1:0];

    // Frame store port
    assign ram_addr = i_cmd.clr_step ? r_clr_addr : {r_frame, slot};
    assign ram_we   = i_cmd.clr_step | i_cmd.alloc_write | i_cmd.leaf_write
                    | i_cmd.unmap_write;

    always_comb begin
        priority if (i_cmd.alloc_write) begin
            ram_wdata = {PAGE_W'(nf_frame), 1'b1};
        end else if (i_cmd.leaf_write) begin
            ram_wdata = {r_page, 1'b1};
        end else if (i_cmd.unmap_write) begin
            ram_wdata = {rd_data[ENTRY_W-1:1], 1'b0};
        end else begin
            ram_wdata = '0;
        end
    end

    rptw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (rd_data)
    );

    // Frame number reduction
    assign mod_start = i_cmd.mod_root | i_cmd.mod_entry;
    assign mod_value = i_cmd.mod_root ? PAGE_W'(r_root) : rd_data[ENTRY_W-1:1];

    rptw_frame_mod #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mod_start),
        .i_value  (mod_value),
        .o_done   (mod_done),
        .o_result (mod_result)
    );

    // Control state: config, allocator count, clear sweep, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root       <= '0;
            r_first_free <= CFG_W'(1);
            r_used       <= '0;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_ROOT_FRAME) begin
                    r_root <= i_cfg_data;
                end else begin
                    r_first_free <= i_cfg_data;
                end
            end
            if (i_cmd.alloc_write) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_kind          <= i_req_type;
            r_vpn           <= i_virt_page;
            r_page          <= i_map_page;
            r_level         <= '0;
            r_first_missing <= LAST_LVL;
        end
        if (i_cmd.adv_level || i_cmd.alloc_write) begin
            r_level <= r_level + 1'b1;
            r_vpn   <= r_vpn << INDEX_BITS;
        end
        if (i_cmd.mark_missing) begin
            r_first_missing <= r_level;
        end
        if (i_cmd.alloc_write) begin
            r_frame <= nf_frame;
        end else if (mod_done) begin
            r_frame <= mod_result;
        end
        if (i_cmd.set_result) begin
            r_status <= i_cmd.result_code;
            r_phys   <= i_cmd.phys_sel ? rd_data[ENTRY_W-1:1] : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_phys   <= r_phys;
        end
    end

    // Status back to the controller
    always_comb begin
        o_sts.clr_last       = r_clr_addr == ADDR_W'(DEPTH - 1);
        o_sts.mod_done       = mod_done;
        o_sts.entry_valid    = rd_data[0];
        o_sts.level_last     = r_level == LAST_LVL;
        o_sts.level_pre_last = ((LVL_W + 1)'(r_level) + 1'b1) == (LVL_W + 1)'(NUM_LEVELS - 1);
        o_sts.fits           = demand <= SUM_W'(NUM_FRAMES);
        o_sts.out_free       = !r_out_valid || !i_out_stall;
        o_sts.kind           = r_kind;
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_phys_page = r_out_phys;

endmodule

FILE: rtl/core/rptw_ctrl.sv
// Walker controller: sequences clearing, table reads, allocation, leaf writes and the result beat.
`timescale 1ns / 1ps

module rptw_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [rptw_pkg::REQ_W-1:0] i_req_type,
    input  rptw_pkg::t_dp_sts          i_sts,
    output rptw_pkg::t_dp_cmd          o_cmd
);
    import rptw_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR     = 9'b000000001,
        S_IDLE      = 9'b000000010,
        S_MOD_WAIT  = 9'b000000100,
        S_RD_WAIT   = 9'b000001000,
        S_EVAL      = 9'b000010000,
        S_ALLOC_CHK = 9'b000100000,
        S_ALLOC_WR  = 9'b001000000,
        S_LEAF_WR   = 9'b010000000,
        S_RESP      = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    if (i_req_type == REQ_NONE) begin
                        o_cmd.set_result  = 1'b1;
                        o_cmd.result_code = ST_OK;
                        n_state           = S_RESP;
                    end else begin
                        o_cmd.mod_root = 1'b1;
                        n_state        = S_MOD_WAIT;
                    end
                end
            end
            S_MOD_WAIT: begin
                if (i_sts.mod_done) begin
                    n_state = S_RD_WAIT;
                end
            end
            S_RD_WAIT: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.kind == REQ_MAP) begin
                    // Find the first missing interior level
                    priority if (i_sts.level_last) begin
                        n_state = S_ALLOC_CHK;
                    end else if (!i_sts.entry_valid) begin
                        o_cmd.mark_missing = 1'b1;
                        n_state            = S_ALLOC_CHK;
                    end else begin
                        o_cmd.mod_entry = 1'b1;
                        o_cmd.adv_level = 1'b1;
                        n_state         = S_MOD_WAIT;
                    end
                end else begin
                    // Query or unmap: follow to the leaf
                    priority if (!i_sts.entry_valid) begin
                        o_cmd.set_result  = 1'b1;
                        o_cmd.result_code = ST_NO_MAP;
                        n_state           = S_RESP;
                    end else if (i_sts.level_last) begin
                        o_cmd.set_result  = 1'b1;
                        o_cmd.result_code = ST_OK;
                        if (i_sts.kind == REQ_QUERY) begin
                            o_cmd.phys_sel = 1'b1;
                        end else begin
                            o_cmd.unmap_write = 1'b1;
                        end
                        n_state = S_RESP;
                    end else begin
                        o_cmd.mod_entry = 1'b1;
                        o_cmd.adv_level = 1'b1;
                        n_state         = S_MOD_WAIT;
                    end
                end
            end
            S_ALLOC_CHK: begin
                priority if (!i_sts.fits) begin
                    o_cmd.set_result  = 1'b1;
                    o_cmd.result_code = ST_NO_FRAMES;
                    n_state           = S_RESP;
                end else if (i_sts.level_last) begin
                    n_state = S_LEAF_WR;
                end else begin
                    n_state = S_ALLOC_WR;
                end
            end
            S_ALLOC_WR: begin
                o_cmd.alloc_write = 1'b1;
                if (i_sts.level_pre_last) begin
                    n_state = S_LEAF_WR;
                end
            end
            S_LEAF_WR: begin
                o_cmd.leaf_write  = 1'b1;
                o_cmd.set_result  = 1'b1;
                o_cmd.result_code = ST_OK;
                n_state           = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

FILE: rtl/core/radix_page_table_walker.sv
// Top level of the multi-level radix page table walker.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  in       | to block  | i_in_valid/o_in_stall   | i_req_type, i_virt_page, i_map_page
//  out      | from block| o_out_valid/i_out_stall | o_status, o_phys_page
//  cfg      | to block  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request at a time. Each table level costs a frame reduction, a read and an
// evaluate step, all on the one frame store port; a map adds a check and one write
// per new level plus the leaf write, and each result goes into the output register.
// After reset a pass clearing all NUM_FRAMES * 2**INDEX_BITS entries holds o_in_stall.
// The result register frees the walk: a new beat is taken while a result waits.
`timescale 1ns / 1ps

module radix_page_table_walker #(
    parameter int NUM_FRAMES = 1024,
    parameter int NUM_LEVELS = 5,
    parameter int INDEX_BITS = 9
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [rptw_pkg::REQ_W-1:0]     i_req_type,
    input  logic [rptw_pkg::VPN_W-1:0]     i_virt_page,
    input  logic [rptw_pkg::PAGE_W-1:0]    i_map_page,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [rptw_pkg::STAT_W-1:0]    o_status,
    output logic [rptw_pkg::PAGE_W-1:0]    o_phys_page,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rptw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rptw_pkg::CFG_W-1:0]     i_cfg_data
);
    import rptw_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    rptw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_req_type (i_req_type),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    rptw_datapath #(
        .NUM_FRAMES (NUM_FRAMES),
        .NUM_LEVELS (NUM_LEVELS),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_req_type  (i_req_type),
        .i_virt_page (i_virt_page),
        .i_map_page  (i_map_page),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_phys_page (o_phys_page)
    );

endmodule

FILE: dv/rptw_checker.sv
// Scoreboard for the page table walker: mirrors the frame store and checks every result beat.
`timescale 1ns / 1ps

module rptw_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [rptw_pkg::REQ_W-1:0]     i_req_type,
    input  logic [rptw_pkg::VPN_W-1:0]     i_virt_page,
    input  logic [rptw_pkg::PAGE_W-1:0]    i_map_page,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [rptw_pkg::STAT_W-1:0]    i_status,
    input  logic [rptw_pkg::PAGE_W-1:0]    i_phys_page,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [rptw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rptw_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_frames_used,
    output int                             o_hits,
    output int                             o_refused
);
    import rptw_pkg::*;

    localparam int LEVELS = 5;
    localparam int SLOT_W = 9;
    localparam int FRAMES = 1024;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PAGE_W-1:0] phys;
    } t_walk_result;

    // Sparse image of the frame store; entries never written read as zero
    logic [ENTRY_W-1:0] frame_mem [int];
    logic [CFG_W-1:0]   root_frame_q;
    logic [CFG_W-1:0]   free_base_q;
    int                 frames_taken;
    t_walk_result       result_q [$];
    int                 mismatches;
    int                 hits;
    int                 refused;
    t_walk_result       want;
    t_walk_result       got;

    function automatic logic [ENTRY_W-1:0] mem_rd(int addr);
        return frame_mem.exists(addr) ? frame_mem[addr] : '0;
    endfunction

    // Frame numbers wrap modulo the frame count; slot is one 9-bit slice, top level first
    function automatic int entry_addr(logic [PAGE_W-1:0] frame, logic [VPN_W-1:0] vpn, int lvl);
        logic [SLOT_W-1:0] slot;
        slot = SLOT_W'(vpn >> ((LEVELS - 1 - lvl) * SLOT_W));
        return int'(frame % FRAMES) * (1 << SLOT_W) + int'(slot);
    endfunction

    // Apply one request to the mirrored store and return the result it must produce
    function automatic t_walk_result walk_request(logic [REQ_W-1:0] kind,
                                                  logic [VPN_W-1:0] vpn,
                                                  logic [PAGE_W-1:0] page);
        t_walk_result       res;
        logic [PAGE_W-1:0]  frame;
        logic [ENTRY_W-1:0] ent;
        int                 addr;
        int                 lvl;
        int                 first_missing;
        int                 need;
        bit                 path_ok;
        res.status = ST_OK;
        res.phys   = '0;
        frame      = PAGE_W'(root_frame_q);
        addr       = 0;
        path_ok    = 1'b1;
        case (kind)
            REQ_QUERY, REQ_UNMAP: begin
                for (lvl = 0; lvl < LEVELS && path_ok; lvl++) begin
                    addr = entry_addr(frame, vpn, lvl);
                    ent  = mem_rd(addr);
                    if (!ent[0]) path_ok = 1'b0;
                    else frame = ent[ENTRY_W-1:1];
                end
                // after a full walk, frame holds the leaf page
                if (!path_ok) res.status = ST_NO_MAP;
                else if (kind == REQ_QUERY) res.phys = frame;
                else frame_mem[addr] = {ent[ENTRY_W-1:1], 1'b0};
            end
            REQ_MAP: begin
                // find the first interior level that is missing
                first_missing = LEVELS - 1;
                for (lvl = 0; lvl < LEVELS - 1 && path_ok; lvl++) begin
                    ent = mem_rd(entry_addr(frame, vpn, lvl));
                    if (!ent[0]) begin
                        path_ok       = 1'b0;
                        first_missing = lvl;
                    end else begin
                        frame = ent[ENTRY_W-1:1];
                    end
                end
                need = LEVELS - 1 - first_missing;
                if (int'(free_base_q) + frames_taken + need > FRAMES) begin
                    res.status = ST_NO_FRAMES;
                end else begin
                    frame = PAGE_W'(root_frame_q);
                    for (lvl = 0; lvl < LEVELS; lvl++) begin
                        addr = entry_addr(frame, vpn, lvl);
                        if (lvl == LEVELS - 1) begin
                            frame_mem[addr] = {page, 1'b1};
                        end else if (lvl < first_missing) begin
                            ent   = mem_rd(addr);
                            frame = ent[ENTRY_W-1:1];
                        end else begin
                            frame = PAGE_W'(int'(free_base_q) + frames_taken);
                            frames_taken++;
                            frame_mem[addr] = {frame, 1'b1};
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic check_field(string what, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t ns: %s mismatch, expected %h, got %h",
                         $time, what, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_mem.delete();
            result_q.delete();
            root_frame_q = '0;
            free_base_q  = 10'd1;
            frames_taken = 0;
            mismatches   = 0;
            hits         = 0;
            refused      = 0;
        end else begin
            // compare the result beat against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                got.status = i_status;
                got.phys   = i_phys_page;
                if (result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t ns: result with no request waiting, status %0d page %h",
                                 $time, got.status, got.phys);
                end else begin
                    want = result_q.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("phys_page", 64'(want.phys), 64'(got.phys));
                end
            end
            // track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROOT_FRAME: root_frame_q = i_cfg_data;
                    CFG_FIRST_FREE: free_base_q = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // predict the request beat
            if (i_in_valid && !i_in_stall) begin
                want = walk_request(i_req_type, i_virt_page, i_map_page);
                if (i_req_type == REQ_QUERY && want.status == ST_OK) hits++;
                if (want.status == ST_NO_FRAMES) refused++;
                result_q.push_back(want);
            end
        end
        o_errors      = mismatches;
        o_pending     = result_q.size();
        o_frames_used = frames_taken;
        o_hits        = hits;
        o_refused     = refused;
    end

endmodule

FILE: dv/tb.sv
// Testbench top for the page table walker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import rptw_pkg::*;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [REQ_W-1:0]     i_req_type  = '0;
    logic [VPN_W-1:0]     i_virt_page = '0;
    logic [PAGE_W-1:0]    i_map_page  = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [STAT_W-1:0]    o_status;
    logic [PAGE_W-1:0]    o_phys_page;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    int fail_count;
    int pending_results;
    int frames_used;
    int lookup_hits;
    int maps_refused;

    // stimulus bookkeeping
    bit               calm = 1'b0;
    int               stall_left = 0;
    int               n_kind [4] = '{0, 0, 0, 0};
    int               n_cfg = 0;
    int               tight_base;
    logic [8:0]       lvl_pool [4][4];
    logic [VPN_W-1:0] known_vpns [$];

    radix_page_table_walker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_virt_page (i_virt_page),
        .i_map_page  (i_map_page),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_phys_page (o_phys_page),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rptw_checker scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_virt_page   (i_virt_page),
        .i_map_page    (i_map_page),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_status      (o_status),
        .i_phys_page   (o_phys_page),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (fail_count),
        .o_pending     (pending_results),
        .o_frames_used (frames_used),
        .o_hits        (lookup_hits),
        .o_refused     (maps_refused)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result channel in random bursts unless the run is calm
    always @(negedge i_clk) begin
        if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 13);
        if (stall_left > 0 && !calm) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end
    end

    // Present one request beat, with an optional gap first, and hold it until taken
    task automatic send_req(logic [REQ_W-1:0] kind, logic [VPN_W-1:0] vpn,
                            logic [PAGE_W-1:0] page);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= kind;
        i_virt_page <= vpn;
        i_map_page  <= page;
        do @(posedge i_clk); while (o_in_stall);
        n_kind[kind]++;
        if (kind == REQ_MAP) begin
            known_vpns.push_back(vpn);
            if (known_vpns.size() > 64) void'(known_vpns.pop_front());
        end
    endtask

    // Drain outstanding results, then write one register while the walker is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    // Mostly paths that share upper levels, sometimes a known page, rarely noise
    function automatic logic [VPN_W-1:0] pick_vpn(bit prefer_known);
        int         r;
        logic [8:0] leaf_idx;
        r = $urandom_range(0, 9);
        if (prefer_known && r < 6 && known_vpns.size() != 0)
            return known_vpns[$urandom_range(0, known_vpns.size() - 1)];
        if (r == 9)
            return VPN_W'({$urandom, $urandom});
        leaf_idx = 9'($urandom_range(0, 511));
        return {lvl_pool[0][$urandom_range(0, 1)], lvl_pool[1][$urandom_range(0, 1)],
                lvl_pool[2][$urandom_range(0, 1)], lvl_pool[3][$urandom_range(0, 3)],
                leaf_idx};
    endfunction

    task automatic run_random(int count, bit settle_calm);
        int               done_items;
        int               r;
        logic [REQ_W-1:0] kind;
        logic [PAGE_W-1:0] page;
        done_items = 0;
        while (done_items < count) begin
            if (settle_calm) calm = 1'b1;
            else if (done_items % 32 == 0) calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 19);
            if (r < 7) kind = REQ_MAP;
            else if (r < 14) kind = REQ_QUERY;
            else if (r < 18) kind = REQ_UNMAP;
            else if (r == 18) kind = REQ_NONE;
            else kind = REQ_QUERY;
            r = $urandom_range(0, 15);
            page = (r == 0) ? '0 : (r == 1) ? '1 : PAGE_W'({$urandom, $urandom});
            send_req(kind, pick_vpn(kind != REQ_MAP || $urandom_range(0, 3) == 0), page);
            if (kind != REQ_NONE) done_items++;
        end
    endtask

    initial begin
        foreach (lvl_pool[l, k]) lvl_pool[l][k] = 9'($urandom_range(0, 511));
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, extremes, shared paths, overwrite, unmap, unused kind
        write_reg(CFG_ROOT_FRAME, 10'd0);
        write_reg(CFG_FIRST_FREE, 10'd1);
        send_req(REQ_QUERY, '0, '0);
        send_req(REQ_UNMAP, '0, '0);
        send_req(REQ_MAP, '0, '0);
        send_req(REQ_QUERY, '0, '1);
        send_req(REQ_MAP, '1, '1);
        send_req(REQ_QUERY, '1, '0);
        send_req(REQ_MAP, 45'd1, 52'h5_5555_5555_5555);
        send_req(REQ_MAP, 45'd1 << 18, PAGE_W'({$urandom, $urandom}));
        send_req(REQ_QUERY, 45'd1 << 9, '0);
        send_req(REQ_QUERY, 45'd2, '0);
        send_req(REQ_MAP, '0, 52'hA_AAAA_AAAA_AAAA);
        send_req(REQ_QUERY, '0, '0);
        send_req(REQ_UNMAP, '0, '0);
        send_req(REQ_QUERY, '0, '0);
        send_req(REQ_UNMAP, '0, '0);
        send_req(REQ_QUERY, 45'd1, '0);
        send_req(REQ_NONE, '0, '0);
        send_req(REQ_NONE, '1, '1);
        send_req(REQ_MAP, 45'h0AAA_AAAA_AAAA, 52'h5_5555_5555_5555);
        send_req(REQ_QUERY, 45'h0AAA_AAAA_AAAA, '0);
        send_req(REQ_UNMAP, '1, '0);
        send_req(REQ_QUERY, '1, '0);

        // Top root frame, allocator from frame zero: new levels land on old tables
        write_reg(CFG_ROOT_FRAME, '1);
        write_reg(CFG_FIRST_FREE, '0);
        run_random(120, 1'b0);

        // Leave room for exactly five more frames under a fresh root
        write_reg(CFG_ROOT_FRAME, 10'd700);
        tight_base = 1024 - frames_used - 5;
        if (tight_base < 0) tight_base = 0;
        if (tight_base > 1023) tight_base = 1023;
        write_reg(CFG_FIRST_FREE, CFG_W'(tight_base));
        run_random(20, 1'b0);

        // Allocator base at the top: maps are refused
        write_reg(CFG_FIRST_FREE, '1);
        run_random(20, 1'b0);

        write_reg(CFG_ROOT_FRAME, CFG_W'($urandom_range(0, 1023)));
        write_reg(CFG_FIRST_FREE, CFG_W'($urandom_range(0, 700)));
        run_random(120, 1'b0);

        // Back to the reset setting; finish without idling
        write_reg(CFG_ROOT_FRAME, 10'd0);
        write_reg(CFG_FIRST_FREE, 10'd1);
        run_random(60, 1'b0);
        run_random(40, 1'b1);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Covered %0d queries, %0d maps, %0d unmaps, %0d unused-kind requests,",
                 n_kind[REQ_QUERY], n_kind[REQ_MAP], n_kind[REQ_UNMAP], n_kind[REQ_NONE]);
        $display("%0d reg writes; %0d lookups hit a mapping, %0d maps were refused.",
                 n_cfg, lookup_hits, maps_refused);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches in total.", fail_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Guard: the clearing pass plus all requests fit well inside this
    initial begin
        #(30_000_000);
        $display("Timed out waiting for the walker.");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
